FILE: rtl/sgu_pkg.sv
// ----------------------------------------------------------------------------
// sgu_pkg
// Shared widths and stage types for the segment geometry unit.
// ----------------------------------------------------------------------------
package sgu_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int RAD_W      = SQ_W + 2;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 4;
    localparam int LEN_W      = COORD_W + 1;
    localparam int UNIT_FRAC  = 30;
    localparam int QUO_W      = UNIT_FRAC + 1;
    localparam int UNIT_W     = UNIT_FRAC + 2;
    localparam int DREM_W     = LEN_W + 1;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int DIV_CELLS  = QUO_W;

    typedef struct packed {
        logic [COORD_W-1:0] mid_x;
        logic [COORD_W-1:0] mid_y;
        logic               neg_x;
        logic               neg_y;
        logic [DIFF_W-1:0]  mag_x;
        logic [DIFF_W-1:0]  mag_y;
    } sgu_carry_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        sgu_carry_t        carry;
    } sgu_sqrt_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [DREM_W-1:0] rx;
        logic [DREM_W-1:0] ry;
        logic [QUO_W-1:0]  qx;
        logic [QUO_W-1:0]  qy;
        sgu_carry_t        carry;
    } sgu_div_t;

endpackage

FILE: rtl/segment_geometry_unit.sv
// ----------------------------------------------------------------------------
// segment_geometry_unit
// Midpoint, length, unit tangent and unit normal of a 2D Q16.16 segment.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser
//  s_*     | in  | start_x, start_y, end_x, end_y (4 x 32) | -
//  m_*     | out | mid_x, mid_y, seg_length, tangent/normal| degenerate
//
//  One transaction per cycle while the output is not stalled; the pipeline is
//  2 front stages, 34 root cells, 31 divider cells and the output register.
//  The whole pipeline advances together: a stall on m_tready holds every
//  cell, and s_tready drops only while the output register is full and stalled.
//  Reset clears the valid bits of all stages; payload registers hold junk.
// ----------------------------------------------------------------------------
module segment_geometry_unit
    import sgu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mid_x[31:0], mid_y[63:32], seg_length[96:64], tangent_x[128:97],
    // tangent_y[160:129], normal_x[192:161], normal_y[224:193], zero fill
    output logic [231:0] m_tdata,
    // degenerate[0]
    output logic [0:0]   m_tuser
);

    logic advance;

    // Front stage 0: differences, magnitudes and midpoints
    logic              v0_reg;
    sgu_carry_t        c0_reg;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] sum_x;
    logic signed [DIFF_W-1:0] sum_y;
    sgu_carry_t        c0_next;

    // Front stage 1: squares
    logic              v1_reg;
    sgu_carry_t        c1_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;
    logic [SQ_W:0]     sq_sum;

    // Cell chains
    logic      sq_v [0:SQRT_CELLS];
    sgu_sqrt_t sq_d [0:SQRT_CELLS];
    logic      dv_v [0:DIV_CELLS];
    sgu_div_t  dv_d [0:DIV_CELLS];

    // Output register
    logic         out_valid_reg;
    logic [231:0] out_data_reg;
    logic         out_degen_reg;
    logic [231:0] out_data_next;
    logic         degen;
    logic [UNIT_W-1:0] tx;
    logic [UNIT_W-1:0] ty;
    logic [UNIT_W-1:0] qx_ext;
    logic [UNIT_W-1:0] qy_ext;
    sgu_div_t     fin;

    // Advance everything unless a finished result is stuck at the output
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    always_comb
    begin
        dx    = $signed({s_tdata[95], s_tdata[95:64]}) - $signed({s_tdata[31], s_tdata[31:0]});
        dy    = $signed({s_tdata[127], s_tdata[127:96]})
              - $signed({s_tdata[63], s_tdata[63:32]});
        sum_x = $signed({s_tdata[95], s_tdata[95:64]}) + $signed({s_tdata[31], s_tdata[31:0]});
        sum_y = $signed({s_tdata[127], s_tdata[127:96]})
              + $signed({s_tdata[63], s_tdata[63:32]});
        c0_next.mid_x = sum_x[DIFF_W-1:1];
        c0_next.mid_y = sum_y[DIFF_W-1:1];
        c0_next.neg_x = dx[DIFF_W-1];
        c0_next.neg_y = dy[DIFF_W-1];
        c0_next.mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        c0_next.mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c0_reg  <= c0_next;
            c1_reg  <= c0_reg;
            sqx_reg <= c0_reg.mag_x * c0_reg.mag_x;
            sqy_reg <= c0_reg.mag_y * c0_reg.mag_y;
        end
    end

    // Feed the root chain: radicand padded to an even bit count
    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_comb
    begin
        sq_d[0].rad   = {1'b0, sq_sum};
        sq_d[0].rem   = '0;
        sq_d[0].root  = '0;
        sq_d[0].carry = c1_reg;
    end
    assign sq_v[0] = v1_reg;

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        sgu_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (sq_v[i]),
            .in_data   (sq_d[i]),
            .out_valid (sq_v[i+1]),
            .out_data  (sq_d[i+1])
        );
    end

    // Hand the length and magnitudes to the divider chain
    always_comb
    begin
        dv_d[0].len   = sq_d[SQRT_CELLS].root[LEN_W-1:0];
        dv_d[0].rx    = {1'b0, sq_d[SQRT_CELLS].carry.mag_x};
        dv_d[0].ry    = {1'b0, sq_d[SQRT_CELLS].carry.mag_y};
        dv_d[0].qx    = '0;
        dv_d[0].qy    = '0;
        dv_d[0].carry = sq_d[SQRT_CELLS].carry;
    end
    assign dv_v[0] = sq_v[SQRT_CELLS];

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        sgu_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (dv_v[j]),
            .in_data   (dv_d[j]),
            .out_valid (dv_v[j+1]),
            .out_data  (dv_d[j+1])
        );
    end

    // Apply signs, drop unit vectors of a zero-length segment
    always_comb
    begin
        fin    = dv_d[DIV_CELLS];
        degen  = (fin.len == '0);
        qx_ext = {1'b0, fin.qx};
        qy_ext = {1'b0, fin.qy};
        tx = degen ? '0 : (fin.carry.neg_x ? (~qx_ext + 1'b1) : qx_ext);
        ty = degen ? '0 : (fin.carry.neg_y ? (~qy_ext + 1'b1) : qy_ext);
        out_data_next = {7'd0, tx, (~ty + 1'b1), ty, tx, fin.len,
                         fin.carry.mid_y, fin.carry.mid_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= dv_v[DIV_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg  <= out_data_next;
            out_degen_reg <= degen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

    // Zero length and the degenerate flag go together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[96:64] == '0) == m_tuser[0]))
        else $error("degenerate flag disagrees with length");

    // A degenerate segment carries zero unit vectors
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[224:97] == '0))
        else $error("unit vectors not cleared on degenerate segment");

    // Normal is the tangent turned by a quarter
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[224:193] == m_tdata[128:97])
                   && (m_tdata[192:161] == 32'(-m_tdata[160:129]))))
        else $error("normal does not match tangent");

    // Input side stalls only behind a stuck result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

endmodule

FILE: rtl/sgu_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sgu_sqrt_cell
// One root digit: shift in two radicand bits, trial subtract, register.
// ----------------------------------------------------------------------------
module sgu_sqrt_cell
    import sgu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      in_valid,
    input  sgu_sqrt_t in_data,
    output logic      out_valid,
    output sgu_sqrt_t out_data
);

    logic      valid_reg;
    sgu_sqrt_t data_reg;
    sgu_sqrt_t data_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb
    begin
        rem_sh = {in_data.rem[REM_W-3:0], in_data.rad[RAD_W-1:RAD_W-2]};
        trial  = {2'b00, in_data.root, 2'b01};
        ge     = (rem_sh >= trial);
        data_next       = in_data;
        data_next.rad   = {in_data.rad[RAD_W-3:0], 2'b00};
        data_next.rem   = ge ? (rem_sh - trial) : rem_sh;
        data_next.root  = {in_data.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/sgu_div_cell.sv
// ----------------------------------------------------------------------------
// sgu_div_cell
// One quotient bit for both tangent lanes: compare, subtract, shift.
// ----------------------------------------------------------------------------
module sgu_div_cell
    import sgu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  logic     in_valid,
    input  sgu_div_t in_data,
    output logic     out_valid,
    output sgu_div_t out_data
);

    logic     valid_reg;
    sgu_div_t data_reg;
    sgu_div_t data_next;
    logic [DREM_W-1:0] den;
    logic [DREM_W-1:0] sub_x;
    logic [DREM_W-1:0] sub_y;
    logic              ge_x;
    logic              ge_y;

    always_comb
    begin
        den   = {1'b0, in_data.len};
        ge_x  = (in_data.rx >= den);
        ge_y  = (in_data.ry >= den);
        sub_x = ge_x ? (in_data.rx - den) : in_data.rx;
        sub_y = ge_y ? (in_data.ry - den) : in_data.ry;
        data_next    = in_data;
        data_next.rx = {sub_x[DREM_W-2:0], 1'b0};
        data_next.ry = {sub_y[DREM_W-2:0], 1'b0};
        data_next.qx = {in_data.qx[QUO_W-2:0], ge_x};
        data_next.qy = {in_data.qy[QUO_W-2:0], ge_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: tb/sv/segment_geometry_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_geometry_unit_tb
// Streams segments through the geometry unit and checks every result against
// a behavioral model of midpoint, length, unit tangent and unit normal.
// ----------------------------------------------------------------------------
module segment_geometry_unit_tb;
    import sgu_pkg::*;

    localparam int  N_RANDOM    = 1300;
    localparam int  LATENCY     = 68;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] mid_x;
        logic [31:0] mid_y;
        logic [32:0] seg_length;
        logic [31:0] tangent_x;
        logic [31:0] tangent_y;
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic        degenerate;
    } geom_t;

    typedef struct {
        logic [31:0] ax, ay, bx, by;
        logic        has_exp;
        geom_t       exp;
    } seg_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [231:0] m_tdata;
    logic [0:0]   m_tuser;

    geom_t  geom_queue[$];
    int     mismatches;
    int     shown;
    longint cycles;
    bit     stim_done;
    bit     long_holdoff;

    segment_geometry_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // floor(sqrt(n)) for n below 2^68, bit by bit from the top
    function automatic logic [33:0] isqrt(logic [67:0] n);
        logic [33:0]  r;
        logic [33:0]  c;
        r = '0;
        for (int i = 33; i >= 0; i--)
        begin
            c = r | (34'd1 << i);
            if ({34'd0, c} * {34'd0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    // signed Q1.30 ratio of a component to the length, truncated toward zero
    function automatic logic [31:0] unit_comp(logic signed [32:0] comp, logic [32:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = comp[32] ? 64'(-comp) : 64'(comp);
        q   = (mag << 30) / {31'd0, len};
        return comp[32] ? 32'(-q) : 32'(q);
    endfunction

    function automatic geom_t segment_geometry(logic [31:0] ax, logic [31:0] ay,
                                               logic [31:0] bx, logic [31:0] by);
        geom_t              g;
        logic signed [32:0] sx, sy, dx, dy;
        logic [32:0]        mx, my;
        logic [67:0]        sq;
        sx = $signed({ax[31], ax}) + $signed({bx[31], bx});
        sy = $signed({ay[31], ay}) + $signed({by[31], by});
        dx = $signed({bx[31], bx}) - $signed({ax[31], ax});
        dy = $signed({by[31], by}) - $signed({ay[31], ay});
        mx = dx[32] ? 33'(-dx) : 33'(dx);
        my = dy[32] ? 33'(-dy) : 33'(dy);
        sq = 68'(mx) * 68'(mx) + 68'(my) * 68'(my);
        g = '0;
        // arithmetic shift right gives the floor of half the sum
        g.mid_x      = 32'(sx >>> 1);
        g.mid_y      = 32'(sy >>> 1);
        g.seg_length = 33'(isqrt(sq));
        g.degenerate = (g.seg_length == 0);
        if (!g.degenerate)
        begin
            g.tangent_x = unit_comp(dx, g.seg_length);
            g.tangent_y = unit_comp(dy, g.seg_length);
        end
        g.normal_x = -g.tangent_y;
        g.normal_y = g.tangent_x;
        return g;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_segment(logic [31:0] ax, logic [31:0] ay,
                                logic [31:0] bx, logic [31:0] by);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {by, bx, ay, ax};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        geom_queue.push_back(segment_geometry(ax, ay, bx, by));
    endtask

    // directed rows: reset-free extremes, coinciding points, axis cases
    seg_row_t dir_rows[] = '{
        '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1,
          '{32'h0, 32'h0, 33'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 33'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
        '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b1,
          '{32'h0000_8000, 32'h0, 33'h1_0000, 32'h4000_0000, 32'h0, 32'h0,
            32'h4000_0000, 1'b0}},
        '{32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 1'b1,
          '{32'h0, 32'hFFFF_8000, 33'h1_0000, 32'h0, 32'hC000_0000, 32'h4000_0000,
            32'h0, 1'b0}},
        '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
        '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b0, '0},
        '{32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b0, '0},
        '{32'h0, 32'h0, 32'h1, 32'h0, 1'b0, '0},
        '{32'h0, 32'h0, 32'h1, 32'h1, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, '0},
        '{32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0}
    };

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        stim_done    = 1'b0;
        long_holdoff = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_segment(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].bx, dir_rows[i].by);
            // typed-in values must agree with the model as well
            if (dir_rows[i].has_exp && geom_queue[$] != dir_rows[i].exp)
            begin
                mismatches++;
                if (shown < 10)
                begin
                    shown++;
                    $display("row %0d: typed %h model %h", i, dir_rows[i].exp,
                             geom_queue[$]);
                end
            end
        end

        // drain fully before the random part
        s_tvalid <= 1'b0;
        while (geom_queue.size() != 0)
            @(posedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 200)
                long_holdoff = 1'b1;
            if (n == 700)
            begin
                s_tvalid <= 1'b0;
                while (geom_queue.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                logic [31:0] px, py;
                px = rand_coord();
                py = rand_coord();
                send_segment(px, py, px, py);
            end
            else if ($urandom_range(0, 3) == 0)
                send_segment($urandom, $urandom, $urandom, $urandom);
            else
                send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, plus one long hold-off to fill the pipe
    initial
    begin
        int wait_n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_holdoff)
            begin
                long_holdoff = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (wait_n != 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        geom_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[96:64], m_tdata[128:97],
                   m_tdata[160:129], m_tdata[192:161], m_tdata[224:193], m_tuser[0]};
            if (geom_queue.size() == 0)
            begin
                mismatches++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected result %h", got);
                end
            end
            else
            begin
                want = geom_queue.pop_front();
                if (got != want || m_tdata[231:225] != '0)
                begin
                    mismatches++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("mismatch: expected mid %h/%h len %h t %h/%h n %h/%h dg %b",
                                 want.mid_x, want.mid_y, want.seg_length, want.tangent_x,
                                 want.tangent_y, want.normal_x, want.normal_y,
                                 want.degenerate);
                        $display("          actual   mid %h/%h len %h t %h/%h n %h/%h dg %b",
                                 got.mid_x, got.mid_y, got.seg_length, got.tangent_x,
                                 got.tangent_y, got.normal_x, got.normal_y,
                                 got.degenerate);
                    end
                end
            end
        end
    end

    // end of run and timeout
    initial
    begin
        cycles = 0;
        mismatches = 0;
        shown = 0;
        while (!(stim_done && geom_queue.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            repeat (LATENCY + 20) @(posedge clk);
            if (mismatches == 0)
                $display("TEST PASSED");
            else
                $display("TEST FAILED");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/sgu_pkg.sv
rtl/sgu_sqrt_cell.sv
rtl/sgu_div_cell.sv
rtl/segment_geometry_unit.sv
tb/sv/segment_geometry_unit_tb.sv
